// ===== hdl/descending_value_sorter_macros.svh =====
//------------------------------------------------------------------------------
// descending_value_sorter assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled during reset.
//------------------------------------------------------------------------------
`ifndef DESCENDING_VALUE_SORTER_MACROS_SVH
`define DESCENDING_VALUE_SORTER_MACROS_SVH

// same-cycle implication
`define DVS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DVS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/dvs_pkg.sv =====
//------------------------------------------------------------------------------
// dvs_pkg
// Widths, defaults and the cell control bundle of the descending value sorter.
//------------------------------------------------------------------------------
package dvs_pkg;

  localparam int SCORE_W   = 7;
  localparam int POS_W     = 6;
  localparam int DVS_COUNT = 64;

  typedef struct packed {
    logic               insert;
    logic               shift;
    logic [SCORE_W-1:0] value;
  } dvs_ctl_t;

endpackage

// ===== hdl/dvs_in_if.sv =====
//------------------------------------------------------------------------------
// dvs_in_if
// Input channel: one score per transfer, final_req marks the last of a set.
//------------------------------------------------------------------------------
interface dvs_in_if import dvs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SCORE_W-1:0] score;
  logic               final_req;

  modport source (output valid, output score, output final_req, input ready);
  modport sink   (input valid, input score, input final_req, output ready);
endinterface

// ===== hdl/dvs_out_if.sv =====
//------------------------------------------------------------------------------
// dvs_out_if
// Result channel: one sorted value per transfer with rank and run flags.
//------------------------------------------------------------------------------
interface dvs_out_if import dvs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SCORE_W-1:0] sorted_value;
  logic [POS_W-1:0]   position;
  logic               end_of_run;
  logic               overflowed;

  modport source (output valid, output sorted_value, output position,
                  output end_of_run, output overflowed, input ready);
  modport sink   (input valid, input sorted_value, input position,
                  input end_of_run, input overflowed, output ready);
endinterface

// ===== hdl/dvs_cell.sv =====
//------------------------------------------------------------------------------
// dvs_cell
// One slot of the sorting chain. Keeps the row in descending order on insert
// and shifts toward the head while the run drains.
//------------------------------------------------------------------------------
module dvs_cell import dvs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  dvs_ctl_t           ctl,
  input  logic               prev_take,
  input  logic [SCORE_W-1:0] prev_val,
  input  logic               prev_vld,
  input  logic [SCORE_W-1:0] next_val,
  input  logic               next_vld,
  output logic               take,
  output logic [SCORE_W-1:0] val,
  output logic               vld
);

  logic [SCORE_W-1:0] val_r, val_nxt;
  logic               vld_r, vld_nxt;

  // empty slots and smaller values yield; equal values stay ahead
  assign take = !vld_r || (ctl.value > val_r);

  always_comb begin
    val_nxt = val_r;
    vld_nxt = vld_r;
    if (ctl.shift) begin
      val_nxt = next_val;
      vld_nxt = next_vld;
    end else if (ctl.insert && take) begin
      if (prev_take) begin
        val_nxt = prev_val;
        vld_nxt = prev_vld;
      end else begin
        val_nxt = ctl.value;
        vld_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;
  assign vld = vld_r;

endmodule

// ===== hdl/descending_value_sorter.sv =====
// Latency: a set's first result is valid the cycle after the transfer of its marked item.
// Throughput: one score per cycle while collecting; then n results, one per cycle
//   while out_ch.ready is high, n being the number held; input is stalled for the
//   whole drain of the cell row.
// Reset (rst_n, synchronous, active low) empties every cell and clears count and flags.
//------------------------------------------------------------------------------
// descending_value_sorter
// Insertion sorter built as a row of COUNT cells kept in descending order.
//------------------------------------------------------------------------------
`include "descending_value_sorter_macros.svh"

module descending_value_sorter import dvs_pkg::*; #(
  parameter int COUNT = DVS_COUNT
) (
  input  logic        clk,
  input  logic        rst_n,
  dvs_in_if.sink      in_ch,
  dvs_out_if.source   out_ch
);

  localparam int CNT_W = $clog2(COUNT + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             drain_r, drain_nxt;
  logic             ovf_r, ovf_nxt;

  logic             in_xfer, out_xfer, full, last_out;
  dvs_ctl_t         ctl;

  logic               take [COUNT];
  logic [SCORE_W-1:0] val  [COUNT];
  logic               vld  [COUNT];

  assign full     = (cnt_r == CNT_W'(COUNT));
  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_xfer = out_ch.valid && out_ch.ready;
  assign last_out = (cnt_r == CNT_W'(1));

  assign ctl.insert = in_xfer && !full;
  assign ctl.shift  = out_xfer;
  assign ctl.value  = in_ch.score;

  for (genvar i = 0; i < COUNT; i++) begin : g_cell
    logic               p_take, p_vld, n_vld;
    logic [SCORE_W-1:0] p_val, n_val;

    if (i == 0) begin : g_head
      assign p_take = 1'b0;
      assign p_val  = '0;
      assign p_vld  = 1'b0;
    end else begin : g_body
      assign p_take = take[i-1];
      assign p_val  = val[i-1];
      assign p_vld  = vld[i-1];
    end

    if (i == COUNT - 1) begin : g_tail
      assign n_val = '0;
      assign n_vld = 1'b0;
    end else begin : g_inner
      assign n_val = val[i+1];
      assign n_vld = vld[i+1];
    end

    dvs_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .prev_take (p_take),
      .prev_val  (p_val),
      .prev_vld  (p_vld),
      .next_val  (n_val),
      .next_vld  (n_vld),
      .take      (take[i]),
      .val       (val[i]),
      .vld       (vld[i])
    );
  end

  always_comb begin
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    drain_nxt = drain_r;
    ovf_nxt   = ovf_r;
    if (in_xfer) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      if (in_ch.final_req) begin
        drain_nxt = 1'b1;
      end
    end
    if (out_xfer) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      pos_nxt = pos_r + POS_W'(1);
      if (last_out) begin
        drain_nxt = 1'b0;
        pos_nxt   = '0;
        ovf_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      pos_r   <= '0;
      drain_r <= 1'b0;
      ovf_r   <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      pos_r   <= pos_nxt;
      drain_r <= drain_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  assign in_ch.ready         = !drain_r;
  assign out_ch.valid        = drain_r;
  assign out_ch.sorted_value = val[0];
  assign out_ch.position     = pos_r;
  assign out_ch.end_of_run   = last_out;
  assign out_ch.overflowed   = ovf_r;

  `DVS_ASSERT_NOW(a_drain_nonempty, drain_r, (cnt_r != '0) && vld[0], "drain with empty row")
  `DVS_ASSERT_NOW(a_head_order, drain_r && vld[1], val[0] >= val[1], "row out of order")
  `DVS_ASSERT_NOW(a_last_alone, out_xfer && last_out, !vld[1], "cells left after last transfer")
  `DVS_ASSERT_NEXT(a_final_starts, in_xfer && in_ch.final_req, drain_r, "marked item did not start drain")
  `DVS_ASSERT_NEXT(a_run_ends, out_xfer && last_out, !drain_r && (cnt_r == '0), "run did not end")

endmodule
